// File: rtl/dcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimating complex FIR package
// Shared widths, state codes, the coefficient table and output finishing.
// ----------------------------------------------------------------------------
package dcf_pkg;

  localparam int TAPS     = 65;
  localparam int TAP_AW   = $clog2(TAPS);
  localparam int SAMPLE_W = 16;
  localparam int COEFF_W  = 16;
  localparam int PROD_W   = SAMPLE_W + COEFF_W;
  localparam int ACC_W    = PROD_W + $clog2(TAPS);
  localparam int RAM_W    = 2 * SAMPLE_W;
  localparam int DECIM_W  = 4;
  localparam int MID      = (TAPS - 1) / 2;

  localparam logic [DECIM_W-1:0] DECIM_RESET = DECIM_W'(2);

  localparam longint PASS_EDGE_HZ   = 10000;
  localparam longint SAMPLE_RATE_HZ = 48000;

  localparam longint          Q30_ONE     = 64'sd1073741824;
  localparam longint          Q26_ONE     = 64'sd67108864;
  localparam longint unsigned Q30_ONE_U   = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          PI_Q30      = 64'sd3373259426;
  localparam longint          HAMM_A_Q30  = 64'sd579820585;
  localparam longint          HAMM_B_Q30  = 64'sd493921239;
  localparam longint unsigned WIN_DIV     = 64'(TAPS - 1);
  localparam longint unsigned CUTOFF_U    = 64'(PASS_EDGE_HZ);
  localparam longint unsigned RATE_U      = 64'(SAMPLE_RATE_HZ);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  function automatic longint sine_q30(input logic [31:0] ph);
    longint unsigned r;
    longint unsigned a;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    r = {34'd0, ph[29:0]};
    if (ph[30]) begin
      r = Q30_ONE_U - r;
    end
    a  = (r * HALF_PI_Q30) >> 30;
    x2 = (a * a) >> 30;
    t  = Q30_ONE_U;
    t  = Q30_ONE_U - ((x2 * t) >> 30) / 64'd156;
    t  = Q30_ONE_U - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE_U - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE_U - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE_U - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE_U - ((x2 * t) >> 30) / 64'd6;
    s  = (a * t) >> 30;
    if (s > Q30_ONE_U) begin
      s = Q30_ONE_U;
    end
    return ph[31] ? -signed'(s) : signed'(s);
  endfunction

  // Unsigned long division by shift and subtract, one quotient bit per step.
  function automatic logic [63:0] udiv64(input logic [63:0] num_i,
                                         input logic [63:0] den_i);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num_i[b]};
      if (rem >= {1'b0, den_i}) begin
        rem    = rem - {1'b0, den_i};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [TAPS*COEFF_W-1:0] build_rom();
    longint                  h [TAPS];
    longint                  sum;
    longint                  lim;
    longint                  c;
    longint                  w;
    longint                  hs;
    longint                  num;
    longint                  q;
    longint                  den;
    longint                  ax_l;
    longint unsigned         wph_u;
    longint unsigned         fr_u;
    longint unsigned         ph_u;
    longint unsigned         ax_u;
    longint unsigned         mag;
    longint unsigned         den_u;
    longint unsigned         qu;
    logic [31:0]             ph32;
    int                      ax;
    logic [TAPS*COEFF_W-1:0] rom;
    sum = 0;
    lim = 64'sd1 <<< (COEFF_W - 1);
    rom = '0;
    for (int n = 0; n < TAPS; n++) begin
      wph_u = n;
      wph_u = (wph_u << 32) / WIN_DIV;
      ph32  = wph_u[31:0] + 32'h4000_0000;
      c     = sine_q30(ph32);
      w     = HAMM_A_Q30 - (HAMM_B_Q30 * c) / Q30_ONE;
      ax    = (n >= MID) ? (n - MID) : (MID - n);
      if (ax == 0) begin
        hs = ((64'sd2 * PASS_EDGE_HZ) <<< 30) / SAMPLE_RATE_HZ;
      end else begin
        ax_u = ax;
        ax_l = ax;
        fr_u = (CUTOFF_U * ax_u) % RATE_U;
        ph_u = (fr_u << 32) / RATE_U;
        num  = sine_q30(ph_u[31:0]) * Q30_ONE;
        mag  = (num < 0) ? -num : num;
        qu   = udiv64(mag, unsigned'(PI_Q30 * ax_l));
        hs   = (num < 0) ? -signed'(qu) : signed'(qu);
      end
      h[n] = (hs * (w >>> 4)) / Q26_ONE;
      sum  = sum + h[n];
    end
    for (int n = 0; n < TAPS; n++) begin
      num   = h[n] * lim;
      den   = (sum > 0) ? sum : Q30_ONE;
      den_u = den;
      mag   = (num < 0) ? -num : num;
      qu    = udiv64(mag + (den_u >> 1), den_u);
      q     = (num < 0) ? -signed'(qu) : signed'(qu);
      if (q > lim - 1) begin
        q = lim - 1;
      end
      if (q < -lim) begin
        q = -lim;
      end
      rom[n*COEFF_W +: COEFF_W] = q[COEFF_W-1:0];
    end
    return rom;
  endfunction

  localparam logic [TAPS*COEFF_W-1:0] COEF_ROM = build_rom();

  function automatic logic signed [COEFF_W-1:0] coef_at(input logic [TAP_AW-1:0] k);
    return COEF_ROM[k*COEFF_W +: COEFF_W];
  endfunction

  localparam logic signed [ACC_W:0] ROUND_HALF = (ACC_W + 1)'(1) <<< (COEFF_W - 2);
  localparam logic signed [ACC_W:0] SAT_HI     = (ACC_W + 1)'((1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W:0] SAT_LO     = -SAT_HI - (ACC_W + 1)'(1);

  function automatic logic signed [SAMPLE_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] v;
    logic signed [ACC_W:0] r;
    logic signed [SAMPLE_W-1:0] res;
    v = (ACC_W + 1)'(acc) + ROUND_HALF;
    r = v >>> (COEFF_W - 1);
    if (r > SAT_HI) begin
      res = SAT_HI[SAMPLE_W-1:0];
    end else if (r < SAT_LO) begin
      res = SAT_LO[SAMPLE_W-1:0];
    end else begin
      res = r[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/dcf_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimating complex FIR channels
// Valid/ready channels for input sample words and filtered result words.
// ----------------------------------------------------------------------------
interface dcf_sample_if;
  import dcf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic signed [SAMPLE_W-1:0] sample_q;

  modport source (output valid, output sample_i, output sample_q, input ready);
  modport sink (input valid, input sample_i, input sample_q, output ready);
endinterface

interface dcf_result_if;
  import dcf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_i;
  logic signed [SAMPLE_W-1:0] out_q;

  modport source (output valid, output out_i, output out_q, input ready);
  modport sink (input valid, input out_i, input out_q, output ready);
endinterface

// File: rtl/dcf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/decimating_complex_fir.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimating complex FIR filter
// Real-coefficient low-pass FIR over I and Q with a programmable decimation.
// ----------------------------------------------------------------------------
// A word that yields no result leaves the filter idle; the next word is taken in the next cycle.
// A word that yields a result starts a pass of one multiply-accumulate per cycle through the
// single delay-line RAM read port, and no word is taken until the pass is done and its result
// is loaded into the output register; an unread earlier result there holds back that load.
// Reset clears the delay line through per-entry valid bits, so no clearing pass is needed;
// the decimation factor resets to 2 and the counters to zero.
module decimating_complex_fir (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dcf_pkg::DECIM_W-1:0]  cfg_wdata_i,
  dcf_sample_if.sink                   in_ch,
  dcf_result_if.source                 out_ch
);
  import dcf_pkg::*;

  state_e                     state_q, state_d;
  logic [DECIM_W-1:0]         decim_q;
  logic [DECIM_W-1:0]         cnt_q;
  logic [DECIM_W-1:0]         cnt_nxt;
  logic [TAP_AW-1:0]          wp_q;
  logic [TAP_AW-1:0]          wp_nxt;
  logic [TAPS-1:0]            valid_q;
  logic                       issuing_q;
  logic [TAP_AW-1:0]          ra_q;
  logic [TAP_AW-1:0]          k_q;
  logic signed [COEFF_W-1:0]  coef_q;
  logic                       s1_q, l1_q, vld1_q;
  logic                       s2_q, l2_q;
  logic signed [PROD_W-1:0]   prod_re_q, prod_im_q;
  logic signed [ACC_W-1:0]    acc_re_q, acc_im_q;
  logic                       out_vld_q;
  logic signed [SAMPLE_W-1:0] out_re_q, out_im_q;
  logic                       in_acc;
  logic                       emit;
  logic                       last_issue;
  logic                       load_out;
  logic                       rd_en;
  logic [RAM_W-1:0]           rdata;
  logic signed [SAMPLE_W-1:0] rd_re, rd_im;

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cnt_nxt     = cnt_q + DECIM_W'(1);
  assign emit        = (cnt_nxt >= decim_q);
  assign wp_nxt      = (wp_q == TAP_AW'(TAPS - 1)) ? '0 : wp_q + TAP_AW'(1);
  assign last_issue  = (k_q == TAP_AW'(TAPS - 1));
  assign rd_en       = (state_q == S_RUN) && issuing_q;
  assign load_out    = (state_q == S_FIN) && (!out_vld_q || out_ch.ready);

  dcf_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TAPS)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wp_q),
    .wdata_i ({in_ch.sample_i, in_ch.sample_q}),
    .re_i    (rd_en),
    .raddr_i (ra_q),
    .rdata_o (rdata)
  );

  assign rd_re = vld1_q ? signed'(rdata[RAM_W-1:SAMPLE_W]) : '0;
  assign rd_im = vld1_q ? signed'(rdata[SAMPLE_W-1:0]) : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && emit) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (s2_q && l2_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      decim_q   <= DECIM_RESET;
      cnt_q     <= '0;
      wp_q      <= '0;
      valid_q   <= '0;
      issuing_q <= 1'b0;
      ra_q      <= '0;
      k_q       <= '0;
      s1_q      <= 1'b0;
      l1_q      <= 1'b0;
      vld1_q    <= 1'b0;
      s2_q      <= 1'b0;
      l2_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        decim_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        valid_q[wp_q] <= 1'b1;
        wp_q          <= wp_nxt;
        cnt_q         <= emit ? '0 : cnt_nxt;
        if (emit) begin
          issuing_q <= 1'b1;
          ra_q      <= wp_nxt;
          k_q       <= '0;
        end
      end
      if (rd_en) begin
        ra_q   <= (ra_q == TAP_AW'(TAPS - 1)) ? '0 : ra_q + TAP_AW'(1);
        k_q    <= k_q + TAP_AW'(1);
        vld1_q <= valid_q[ra_q];
        if (last_issue) begin
          issuing_q <= 1'b0;
        end
      end
      s1_q <= rd_en;
      l1_q <= rd_en && last_issue;
      s2_q <= s1_q;
      l2_q <= s1_q && l1_q;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      coef_q <= coef_at(k_q);
    end
    if (s1_q) begin
      prod_re_q <= rd_re * coef_q;
      prod_im_q <= rd_im * coef_q;
    end
    if (in_acc && emit) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (s2_q) begin
      acc_re_q <= acc_re_q + ACC_W'(prod_re_q);
      acc_im_q <= acc_im_q + ACC_W'(prod_im_q);
    end
    if (load_out) begin
      out_re_q <= finish(acc_re_q);
      out_im_q <= finish(acc_im_q);
    end
  end

  assign out_ch.valid = out_vld_q;
  assign out_ch.out_i = out_re_q;
  assign out_ch.out_q = out_im_q;

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= TAP_AW'(TAPS - 1))
    else $error("delay line write position out of range");

  a_last_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_q && l2_q) |-> (!issuing_q && !s1_q))
    else $error("last product accumulated while reads still pending");

  a_fin_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> (!issuing_q && !s1_q && !s2_q))
    else $error("finishing while the datapath is still busy");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && emit) |=> (issuing_q && k_q == '0 && ra_q == wp_q))
    else $error("filter pass did not start at the oldest sample");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimating complex FIR testbench
// Runs a directed table and then random sample streams through the filter
// under several decimation factors, with bursty input and a stalling output.
// Every result word is checked against a bit-exact software filter built
// here from the windowed-sinc coefficient design, or against a table value.
// ----------------------------------------------------------------------------
module tb_top;
  import dcf_pkg::*;

  localparam int     WATCHDOG     = 2000;
  localparam int     SETTLE       = TAPS + 16;
  localparam int     PLAN_N       = 22;
  localparam int     RAND_WORDS   = 30;
  localparam int     MAX_REPORTS  = 30;
  localparam longint ONE_Q30      = 64'sd1 <<< 30;
  localparam longint ONE_Q26      = 64'sd1 <<< 26;
  localparam longint K_HALF_PI    = 64'sd1686629713;
  localparam longint K_PI         = 64'sd3373259426;
  localparam longint K_HAMM_A     = 64'sd579820585;
  localparam longint K_HAMM_B     = 64'sd493921239;
  localparam longint CUTOFF       = 64'sd10000;
  localparam longint RATE         = 64'sd48000;
  localparam longint COEF_LIM     = 64'sd1 <<< (COEFF_W - 1);
  localparam longint OUT_TOP      = (64'sd1 <<< (SAMPLE_W - 1)) - 1;

  typedef logic signed [SAMPLE_W-1:0] smp_t;

  typedef struct packed {
    smp_t re;
    smp_t im;
  } iq_t;

  typedef struct packed {
    bit                 wr;
    logic [DECIM_W-1:0] factor;
    smp_t               si;
    smp_t               sq;
    bit                 typed;
    smp_t               ei;
    smp_t               eq;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [DECIM_W-1:0] cfg_wdata;

  dcf_sample_if in_ch ();
  dcf_result_if out_ch ();

  decimating_complex_fir dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  int                 coef_tab [TAPS];
  smp_t               line_i [TAPS];
  smp_t               line_q [TAPS];
  int                 wr_pos;
  logic [DECIM_W-1:0] decim_cnt;
  logic [DECIM_W-1:0] decim_factor;
  iq_t                expected_q [$];

  int          errors;
  int          reports;
  int          words_sent;
  int          results_seen;
  int          settings_used;
  int          quiet;
  int          burst_left;
  int          gap_max;
  logic [15:0] ready_mask;
  logic [3:0]  rx_slot;
  row_t        plan [PLAN_N];
  logic [DECIM_W-1:0] phase_factor [10];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint turn_sine(input logic [31:0] ph);
    longint unsigned divs [6];
    longint unsigned r;
    longint unsigned a;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    r = 64'(ph[29:0]);
    if (ph[30]) begin
      r = (64'd1 << 30) - r;
    end
    a  = (r * 64'd1686629713) >> 30;
    x2 = (a * a) >> 30;
    t  = 64'd1 << 30;
    for (int k = 0; k < 6; k++) begin
      t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[k];
    end
    s = (a * t) >> 30;
    if (s > (64'd1 << 30)) begin
      s = 64'd1 << 30;
    end
    return ph[31] ? -signed'(s) : signed'(s);
  endfunction

  function automatic void design_taps();
    longint          h [TAPS];
    longint          total;
    longint          c;
    longint          w;
    longint          hs;
    longint          span;
    longint          frs;
    longint          phs;
    longint          num;
    longint          den;
    longint          q;
    longint unsigned ph64;
    longint unsigned mag;
    longint unsigned qu;
    logic [31:0]     ph32;
    total = 0;
    for (int n = 0; n < TAPS; n++) begin
      ph64 = 64'(n);
      ph64 = (ph64 << 32) / 64'(TAPS - 1);
      ph32 = ph64[31:0] + 32'h4000_0000;
      c    = turn_sine(ph32);
      w    = K_HAMM_A - (K_HAMM_B * c) / ONE_Q30;
      span = (n >= (TAPS - 1) / 2) ? n - (TAPS - 1) / 2 : (TAPS - 1) / 2 - n;
      if (span == 0) begin
        hs = ((64'sd2 * CUTOFF) <<< 30) / RATE;
      end else begin
        frs = (CUTOFF * span) % RATE;
        phs = (frs <<< 32) / RATE;
        hs  = (turn_sine(phs[31:0]) * ONE_Q30) / (K_PI * span);
      end
      h[n]  = (hs * (w >>> 4)) / ONE_Q26;
      total = total + h[n];
    end
    den = (total > 0) ? total : ONE_Q30;
    for (int n = 0; n < TAPS; n++) begin
      num = h[n] * COEF_LIM;
      mag = (num < 0) ? -num : num;
      qu  = (mag + den / 2) / den;
      q   = (num < 0) ? -signed'(qu) : signed'(qu);
      if (q > COEF_LIM - 1) begin
        q = COEF_LIM - 1;
      end
      if (q < -COEF_LIM) begin
        q = -COEF_LIM;
      end
      coef_tab[n] = int'(q);
    end
  endfunction

  function automatic smp_t to_q15(input longint acc);
    longint v;
    v = (acc + (64'sd1 <<< (COEFF_W - 2))) >>> (COEFF_W - 1);
    if (v > OUT_TOP) begin
      v = OUT_TOP;
    end else if (v < -OUT_TOP - 1) begin
      v = -OUT_TOP - 1;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic bit advance_filter(input smp_t si, input smp_t sq, output iq_t res);
    longint acc_i;
    longint acc_q;
    int     idx;
    res            = '0;
    line_i[wr_pos] = si;
    line_q[wr_pos] = sq;
    wr_pos         = (wr_pos + 1) % TAPS;
    decim_cnt      = decim_cnt + 1'b1;
    if (decim_cnt < decim_factor) begin
      return 1'b0;
    end
    decim_cnt = '0;
    acc_i     = 0;
    acc_q     = 0;
    idx       = wr_pos;
    for (int k = 0; k < TAPS; k++) begin
      acc_i = acc_i + longint'(line_i[idx]) * coef_tab[k];
      acc_q = acc_q + longint'(line_q[idx]) * coef_tab[k];
      idx   = (idx + 1) % TAPS;
    end
    res.re = to_q15(acc_i);
    res.im = to_q15(acc_q);
    return 1'b1;
  endfunction

  function automatic smp_t draw_sample(input smp_t prev);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SAMPLE_W'($urandom);
      4:          return 16'sh7FFF;
      5:          return 16'sh8000;
      6, 7:       return prev;
      8:          return SAMPLE_W'($urandom_range(0, 63) - 32);
      default:    return -prev;
    endcase
  endfunction

  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0:       ready_mask = 16'hFFFF;
      1:       ready_mask = 16'h00FF;
      2:       ready_mask = 16'h8001;
      default: ready_mask = 16'($urandom) | 16'h0001;
    endcase
    gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
  endtask

  task automatic push_word(input smp_t si, input smp_t sq, input bit typed, input iq_t fixed);
    iq_t res;
    bit  emits;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, gap_max)) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_ch.valid    <= 1'b1;
    in_ch.sample_i <= si;
    in_ch.sample_q <= sq;
    do @(posedge clk_i); while (!in_ch.ready);
    emits = advance_filter(si, sq, res);
    if (emits) begin
      expected_q.push_back(typed ? fixed : res);
    end
    words_sent++;
  endtask

  task automatic set_decimation(input logic [DECIM_W-1:0] f);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= f;
    @(negedge clk_i);
    cfg_we       <= 1'b0;
    decim_factor = f;
    burst_left   = 0;
    settings_used++;
  endtask

  always @(negedge clk_i) begin
    out_ch.ready <= ready_mask[rx_slot];
    rx_slot      <= rx_slot + 1'b1;
  end

  always @(posedge clk_i) begin
    iq_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          $display("%0t: unexpected result word, expected none, actual %0d / %0d",
                   $time, out_ch.out_i, out_ch.out_q);
        end
        reports++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.out_i !== want.re) begin
          errors++;
          if (reports < MAX_REPORTS) begin
            $display("%0t: out_i mismatch, expected %0d, actual %0d",
                     $time, want.re, out_ch.out_i);
          end
          reports++;
        end
        if (out_ch.out_q !== want.im) begin
          errors++;
          if (reports < MAX_REPORTS) begin
            $display("%0t: out_q mismatch, expected %0d, actual %0d",
                     $time, want.im, out_ch.out_q);
          end
          reports++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG);
        $display("decimating_complex_fir regression: fail");
        $finish;
      end
    end
  end

  initial begin
    smp_t cur_i;
    smp_t cur_q;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.sample_i = '0;
    in_ch.sample_q = '0;
    out_ch.ready   = 1'b0;
    rx_slot        = '0;
    ready_mask     = 16'($urandom) | 16'h0001;
    gap_max        = 4;
    burst_left     = 0;
    quiet          = 0;
    errors         = 0;
    reports        = 0;
    words_sent     = 0;
    results_seen   = 0;
    settings_used  = 1;
    wr_pos         = 0;
    decim_cnt      = '0;
    decim_factor   = 4'd2;
    cur_i          = '0;
    cur_q          = '0;
    for (int n = 0; n < TAPS; n++) begin
      line_i[n] = '0;
      line_q[n] = '0;
    end
    design_taps();

    plan = '{
      '{1'b0, 4'd0,  16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'h0001, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'hFFFF, 16'h0001, 1'b0, 16'h0000, 16'h0000},
      '{1'b1, 4'd0,  16'h4000, 16'hC000, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'h5555, 16'hAAAA, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'hAAAA, 16'h5555, 1'b0, 16'h0000, 16'h0000},
      '{1'b1, 4'd15, 16'h0064, 16'hFF9C, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'h0000, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'hFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'h2468, 16'hDB98, 1'b0, 16'h0000, 16'h0000},
      '{1'b1, 4'd4,  16'h1234, 16'hEDCC, 1'b0, 16'h0000, 16'h0000},
      '{1'b1, 4'd1,  16'h7FFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'h8000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{1'b1, 4'd15, 16'h0001, 16'h0001, 1'b0, 16'h0000, 16'h0000},
      '{1'b0, 4'd0,  16'hFFFE, 16'hFFFE, 1'b0, 16'h0000, 16'h0000}
    };
    phase_factor = '{4'd1, 4'd15, 4'd0, 4'd2, 4'd5, 4'd8, 4'd3, 4'd14, 4'd1, 4'd6};
    phase_factor[9] = DECIM_W'($urandom_range(0, 15));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table. A count left over from a factor of 15 is checked
    // against a smaller factor, which must fire on the next word.
    for (int r = 0; r < PLAN_N; r++) begin
      if (plan[r].wr) begin
        set_decimation(plan[r].factor);
      end
      push_word(plan[r].si, plan[r].sq, plan[r].typed, {plan[r].ei, plan[r].eq});
    end

    for (int p = 0; p < 10; p++) begin
      set_decimation(phase_factor[p]);
      pick_idling();
      // Full-scale words with the signs of the taps drive both rails into
      // saturation, high on one and low on the other, then the reverse.
      if (p == 0) begin
        for (int pass = 0; pass < 2; pass++) begin
          for (int k = 0; k < TAPS; k++) begin
            cur_i = ((coef_tab[k] < 0) ^ (pass == 1)) ? 16'sh8000 : 16'sh7FFF;
            cur_q = ~cur_i;
            push_word(cur_i, cur_q, 1'b0, '0);
          end
        end
      end
      for (int n = 0; n < RAND_WORDS; n++) begin
        cur_i = draw_sample(cur_i);
        cur_q = draw_sample(cur_q);
        push_word(cur_i, cur_q, 1'b0, '0);
      end
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("Sent %0d sample words and checked %0d filtered results", words_sent, results_seen);
    $display("over %0d decimation settings, including zero, one and fifteen.", settings_used);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("decimating_complex_fir regression: pass");
    end else begin
      $display("decimating_complex_fir regression: fail");
    end
    $finish;
  end

endmodule
